>>> design/tji_pkg.sv
// Shared widths, payload types and saturation helpers for the tetra Jacobian inverse unit.
package tji_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int FIELD_W     = 16;
   localparam int EDGE_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * EDGE_W;
   localparam int ADJ_W       = PROD_W + 1;
   localparam int DP_W        = EDGE_W + ADJ_W;
   localparam int DET_INT_W   = DP_W + 2;
   localparam int DIV_SHIFT   = 24;
   localparam int NUM_W       = ADJ_W + DIV_SHIFT;
   localparam int REM_W       = DET_INT_W;
   localparam int ELEM_W      = 40;
   localparam int DET_W       = 56;
   localparam int NUM_ELEM    = 9;
   localparam int FRONT_LAT   = 5;
   localparam int TOTAL_LAT   = FRONT_LAT + NUM_W + 1;
   localparam int WIDE_W      = 128;

   localparam logic signed [WIDE_W-1:0] ELEM_MAX = (WIDE_W'(1) <<< (ELEM_W - 1)) - 1;
   localparam logic signed [WIDE_W-1:0] ELEM_MIN = -(WIDE_W'(1) <<< (ELEM_W - 1));
   localparam logic signed [WIDE_W-1:0] DETV_MAX = (WIDE_W'(1) <<< (DET_W - 1)) - 1;
   localparam logic signed [WIDE_W-1:0] DETV_MIN = -(WIDE_W'(1) <<< (DET_W - 1));
   localparam logic [NUM_W:0] ELEM_HALF_Q = (NUM_W + 1)'(1) << (ELEM_W - 1);

   typedef logic signed [EDGE_W-1:0] edge_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ADJ_W-1:0]  adj_type;
   typedef logic signed [DP_W-1:0]   dp_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] p0_x;
      logic signed [FIELD_W-1:0] p1_x;
      logic signed [FIELD_W-1:0] p2_x;
      logic signed [FIELD_W-1:0] p3_x;
      logic signed [FIELD_W-1:0] p0_y;
      logic signed [FIELD_W-1:0] p1_y;
      logic signed [FIELD_W-1:0] p2_y;
      logic signed [FIELD_W-1:0] p3_y;
      logic signed [FIELD_W-1:0] p0_z;
      logic signed [FIELD_W-1:0] p1_z;
      logic signed [FIELD_W-1:0] p2_z;
      logic signed [FIELD_W-1:0] p3_z;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] elem_0;
      logic signed [ELEM_W-1:0] elem_1;
      logic signed [ELEM_W-1:0] elem_2;
      logic signed [ELEM_W-1:0] elem_3;
      logic signed [ELEM_W-1:0] elem_4;
      logic signed [ELEM_W-1:0] elem_5;
      logic signed [ELEM_W-1:0] elem_6;
      logic signed [ELEM_W-1:0] elem_7;
      logic signed [ELEM_W-1:0] elem_8;
      logic signed [DET_W-1:0]  det_value;
      logic                     det_zero;
   } rsp_type;

   // One transaction as it moves through the divider chain.
   typedef struct packed {
      logic                              valid;
      logic                              mode;
      logic                              zero;
      logic [DET_INT_W-1:0]              det;
      logic [NUM_ELEM-1:0][ADJ_W-1:0]    adj;
      logic [NUM_ELEM-1:0]               neg;
      logic [REM_W-1:0]                  den;
      logic [NUM_ELEM-1:0][REM_W-1:0]    rem;
      logic [NUM_ELEM-1:0][NUM_W-1:0]    work;
   } div_type;

   function automatic edge_type coord_ext(logic [FIELD_W-1:0] v);
      logic signed [COORD_WIDTH-1:0] c;
      c = signed'(v[COORD_WIDTH-1:0]);
      return EDGE_W'(c);
   endfunction

   function automatic logic [ELEM_W-1:0] sat_adj(logic [ADJ_W-1:0] v);
      logic signed [WIDE_W-1:0] w;
      w = WIDE_W'(signed'(v));
      if (w > ELEM_MAX) return ELEM_MAX[ELEM_W-1:0];
      if (w < ELEM_MIN) return ELEM_MIN[ELEM_W-1:0];
      return w[ELEM_W-1:0];
   endfunction

   function automatic logic [DET_W-1:0] sat_det(logic [DET_INT_W-1:0] v);
      logic signed [WIDE_W-1:0] w;
      w = WIDE_W'(signed'(v));
      if (w > DETV_MAX) return DETV_MAX[DET_W-1:0];
      if (w < DETV_MIN) return DETV_MIN[DET_W-1:0];
      return w[DET_W-1:0];
   endfunction

endpackage

>>> design/tji_front.sv
// Edge vectors, adjugate and determinant over five register stages.
module tji_front
   import tji_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  logic    in_mode,
   input  req_type in_data,
   output div_type out_stage
);

   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic     s1_mode_ff, s2_mode_ff, s3_mode_ff, s4_mode_ff;
   edge_type s1_e_ff [3][3];
   edge_type s1_e_in [3][3];
   edge_type s2_e0_ff [3];
   edge_type s3_e0_ff [3];
   prod_type s2_pp_ff [3][3];
   prod_type s2_pm_ff [3][3];
   adj_type  s3_adj_ff [3][3];
   adj_type  s4_adj_ff [3][3];
   dp_type   s4_dp_ff [3];
   logic signed [DET_INT_W-1:0] det_sum;
   div_type  s5_in;
   div_type  s5_ff;

   always_comb begin
      s1_e_in[0][0] = coord_ext(in_data.p1_x) - coord_ext(in_data.p0_x);
      s1_e_in[0][1] = coord_ext(in_data.p1_y) - coord_ext(in_data.p0_y);
      s1_e_in[0][2] = coord_ext(in_data.p1_z) - coord_ext(in_data.p0_z);
      s1_e_in[1][0] = coord_ext(in_data.p2_x) - coord_ext(in_data.p0_x);
      s1_e_in[1][1] = coord_ext(in_data.p2_y) - coord_ext(in_data.p0_y);
      s1_e_in[1][2] = coord_ext(in_data.p2_z) - coord_ext(in_data.p0_z);
      s1_e_in[2][0] = coord_ext(in_data.p3_x) - coord_ext(in_data.p0_x);
      s1_e_in[2][1] = coord_ext(in_data.p3_y) - coord_ext(in_data.p0_y);
      s1_e_in[2][2] = coord_ext(in_data.p3_z) - coord_ext(in_data.p0_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff <= in_mode;
      s2_mode_ff <= s1_mode_ff;
      s3_mode_ff <= s2_mode_ff;
      s4_mode_ff <= s3_mode_ff;
      s1_e_ff    <= s1_e_in;
      s2_e0_ff   <= s1_e_ff[0];
      s3_e0_ff   <= s2_e0_ff;
   end

   // Adjugate entry (i,j) is the cofactor of J at (j,i), indices taken modulo three.
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R1 = (j + 1) % 3;
         localparam int R2 = (j + 2) % 3;
         localparam int C1 = (i + 1) % 3;
         localparam int C2 = (i + 2) % 3;
         always_ff @(posedge clock) begin
            s2_pp_ff[i][j]  <= s1_e_ff[R1][C1] * s1_e_ff[R2][C2];
            s2_pm_ff[i][j]  <= s1_e_ff[R1][C2] * s1_e_ff[R2][C1];
            s3_adj_ff[i][j] <= ADJ_W'(s2_pp_ff[i][j]) - ADJ_W'(s2_pm_ff[i][j]);
            s4_adj_ff[i][j] <= s3_adj_ff[i][j];
         end
      end
      always_ff @(posedge clock) begin
         s4_dp_ff[i] <= s3_e0_ff[i] * s3_adj_ff[i][0];
      end
   end

   assign det_sum = DET_INT_W'(s4_dp_ff[0]) + DET_INT_W'(s4_dp_ff[1])
                  + DET_INT_W'(s4_dp_ff[2]);

   always_comb begin
      logic [ADJ_W-1:0] mag;
      s5_in.valid = s4_valid_ff;
      s5_in.mode  = s4_mode_ff;
      s5_in.zero  = (det_sum == '0);
      s5_in.det   = det_sum;
      s5_in.den   = det_sum[DET_INT_W-1] ? REM_W'(-det_sum) : REM_W'(det_sum);
      for (int k = 0; k < NUM_ELEM; k++) begin
         s5_in.adj[k] = s4_adj_ff[k / 3][k % 3];
         mag = s4_adj_ff[k / 3][k % 3][ADJ_W-1] ? ADJ_W'(-s4_adj_ff[k / 3][k % 3])
                                                : ADJ_W'(s4_adj_ff[k / 3][k % 3]);
         s5_in.neg[k]  = s4_adj_ff[k / 3][k % 3][ADJ_W-1] ^ det_sum[DET_INT_W-1];
         s5_in.rem[k]  = '0;
         s5_in.work[k] = {mag, {DIV_SHIFT{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      s5_ff <= s5_in;
      if (reset) s5_ff.valid <= 1'b0;
   end

   assign out_stage = s5_ff;

endmodule

>>> design/tji_div_step.sv
// One restoring division step for all nine entries, with its pipeline register.
module tji_div_step
   import tji_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  div_type in_stage,
   output div_type out_stage
);

   div_type step_in;
   div_type step_ff;

   always_comb begin
      logic [REM_W:0] trial;
      logic [REM_W:0] diff;
      step_in = in_stage;
      for (int k = 0; k < NUM_ELEM; k++) begin
         trial = {in_stage.rem[k], in_stage.work[k][NUM_W-1]};
         diff  = trial - {1'b0, in_stage.den};
         if (!diff[REM_W]) begin
            step_in.rem[k]  = diff[REM_W-1:0];
            step_in.work[k] = {in_stage.work[k][NUM_W-2:0], 1'b1};
         end else begin
            step_in.rem[k]  = trial[REM_W-1:0];
            step_in.work[k] = {in_stage.work[k][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (reset) step_ff.valid <= 1'b0;
   end

   assign out_stage = step_ff;

endmodule

>>> design/tji_divider.sv
// Chain of division steps, one quotient bit per stage.
module tji_divider
   import tji_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  div_type in_stage,
   output div_type out_stage
);

   div_type chain [NUM_W+1];

   assign chain[0] = in_stage;

   for (genvar s = 0; s < NUM_W; s++) begin : g_step
      tji_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (chain[s]),
         .out_stage (chain[s+1])
      );
   end

   assign out_stage = chain[NUM_W];

endmodule

>>> design/tji_final.sv
// Output formatting: sign, saturation and mode selection of the matrix entries.
module tji_final
   import tji_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  div_type in_stage,
   output logic    out_valid,
   output rsp_type out_data
);

   logic [NUM_ELEM-1:0][ELEM_W-1:0] elem;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    valid_ff;

   always_comb begin
      logic [NUM_W:0] q;
      for (int k = 0; k < NUM_ELEM; k++) begin
         q = {1'b0, in_stage.work[k]};
         if (in_stage.mode) begin
            elem[k] = sat_adj(in_stage.adj[k]);
         end else if (in_stage.zero) begin
            elem[k] = '0;
         end else if (in_stage.neg[k]) begin
            elem[k] = (q > ELEM_HALF_Q) ? ELEM_MIN[ELEM_W-1:0] : ELEM_W'(-q);
         end else begin
            elem[k] = (q > ELEM_HALF_Q - 1'b1) ? ELEM_MAX[ELEM_W-1:0] : q[ELEM_W-1:0];
         end
      end
      rsp_in.elem_0    = elem[0];
      rsp_in.elem_1    = elem[1];
      rsp_in.elem_2    = elem[2];
      rsp_in.elem_3    = elem[3];
      rsp_in.elem_4    = elem[4];
      rsp_in.elem_5    = elem[5];
      rsp_in.elem_6    = elem[6];
      rsp_in.elem_7    = elem[7];
      rsp_in.elem_8    = elem[8];
      rsp_in.det_value = sat_det(in_stage.det);
      rsp_in.det_zero  = in_stage.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= in_stage.valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

>>> design/tetra_jacobian_inverse_unit.sv
// Top level of the tetra Jacobian inverse unit.
// Accepts one tetrahedron per clock whenever busy is low (busy is high only during reset) and
// returns its result on rsp_strobe, in order. The pipeline is five stages of edge, product,
// adjugate and determinant arithmetic, then one stage per quotient bit of the 59-bit restoring
// divider, then an output register. The receiver cannot stall, so no transaction is ever held
// back. The output mode is sampled with each transaction.
module tetra_jacobian_inverse_unit
   import tji_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   logic    mode_ff;
   logic    mode_in;
   div_type front_out;
   div_type div_out;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else       mode_ff <= mode_in;
   end

   tji_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_mode   (mode_ff),
      .in_data   (req_data),
      .out_stage (front_out)
   );

   tji_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (front_out),
      .out_stage (div_out)
   );

   tji_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (div_out),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

   // Each result traces back to exactly one accepted transaction.
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, TOTAL_LAT))
      else $error("result without a matching accepted transaction");

   a_accept_strobe: assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy, TOTAL_LAT) && !$past(reset, TOTAL_LAT - 1) |-> rsp_strobe)
      else $error("accepted transaction produced no result");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.det_zero == (rsp_data.det_value == '0)))
      else $error("zero flag disagrees with determinant");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

endmodule
